### src/ezr_pkg.sv
package ezr_pkg;

  // input word
  typedef struct packed {
    logic [15:0]        roll_angle;
    logic [15:0]        pitch_angle;
    logic [15:0]        yaw_angle;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } in_word_t;

  // result word, one per matrix row
  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] col0;
    logic signed [15:0] col1;
    logic signed [15:0] col2;
    logic signed [31:0] shift_out;
    logic               last_row;
  } out_word_t;

  localparam int CORDIC_STEPS = 28;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic [1:0] ROW_LAST = 2'd2;

  // cordic angle table, 2^-32 turn units
  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round to nearest, ties away from zero, shift by 30
  function automatic logic signed [32:0] rnd30(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] q;
    m = v[67] ? 68'(-v) : v;
    q = (m + (68'd1 << 29)) >> 30;
    return v[67] ? 33'(-q) : 33'(q);
  endfunction

endpackage

### src/ezr_cordic.sv
// three sine/cosine pipelines, four cordic steps per stage
module ezr_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  ezr_pkg::in_word_t        in_word,
  output logic                     out_valid,
  output ezr_pkg::in_word_t        out_word,
  output logic signed [3*34-1:0]   sin_out,
  output logic signed [3*34-1:0]   cos_out
);
  import ezr_pkg::*;

  logic signed [33:0] x_r [CORDIC_STAGES+1][3];
  logic signed [33:0] y_r [CORDIC_STAGES+1][3];
  logic signed [33:0] z_r [CORDIC_STAGES+1][3];
  logic               f_r [CORDIC_STAGES+1][3];
  logic               v_r [CORDIC_STAGES+1];
  in_word_t           w_r [CORDIC_STAGES+1];

  // angle preparation into stage 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [15:0] ang;
    logic [31:0] a;
    logic        fl;
    if (adv) begin
      w_r[0] <= in_word;
      for (int k = 0; k < 3; k++) begin
        ang = (k == 0) ? in_word.roll_angle :
              (k == 1) ? in_word.pitch_angle : in_word.yaw_angle;
        a = (32'(ang) & ((32'd1 << ANGLE_BITS) - 32'd1)) << (32 - ANGLE_BITS);
        fl = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (fl) a = a - 32'h8000_0000;
        x_r[0][k] <= CORDIC_X0;
        y_r[0][k] <= '0;
        z_r[0][k] <= 34'(signed'(a));
        f_r[0][k] <= fl;
      end
    end
  end

  // cordic stages
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (adv) begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      logic signed [33:0] x, y, z, dx, dy;
      if (adv) begin
        w_r[s+1] <= w_r[s];
        for (int k = 0; k < 3; k++) begin
          x = x_r[s][k]; y = y_r[s][k]; z = z_r[s][k];
          for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            dx = y >>> (s*STEPS_PER_STAGE + j);
            dy = x >>> (s*STEPS_PER_STAGE + j);
            if (!z[33]) begin
              x = x - dx; y = y + dy; z = z - atan_turn(s*STEPS_PER_STAGE + j);
            end else begin
              x = x + dx; y = y - dy; z = z + atan_turn(s*STEPS_PER_STAGE + j);
            end
          end
          x_r[s+1][k] <= x; y_r[s+1][k] <= y; z_r[s+1][k] <= z;
          f_r[s+1][k] <= f_r[s][k];
        end
      end
    end
  end

  // flip and clamp
  always_comb begin
    logic signed [33:0] x, y;
    for (int k = 0; k < 3; k++) begin
      x = f_r[CORDIC_STAGES][k] ? -x_r[CORDIC_STAGES][k] : x_r[CORDIC_STAGES][k];
      y = f_r[CORDIC_STAGES][k] ? -y_r[CORDIC_STAGES][k] : y_r[CORDIC_STAGES][k];
      if (x > Q30_ONE) x = Q30_ONE; else if (x < -Q30_ONE) x = -Q30_ONE;
      if (y > Q30_ONE) y = Q30_ONE; else if (y < -Q30_ONE) y = -Q30_ONE;
      cos_out[k*34 +: 34] = x;
      sin_out[k*34 +: 34] = y;
    end
  end

  assign out_valid = v_r[CORDIC_STAGES];
  assign out_word  = w_r[CORDIC_STAGES];
endmodule

### src/ezr_matrix.sv
// rotation matrix products, two multiply stages and a register stage ahead of rounding
module ezr_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  ezr_pkg::in_word_t      in_word,
  input  logic signed [3*34-1:0] sin_in,
  input  logic signed [3*34-1:0] cos_in,
  output logic                   out_valid,
  output ezr_pkg::in_word_t      out_word,
  output logic signed [9*16-1:0] ent_out
);
  import ezr_pkg::*;

  logic signed [33:0] sr_r, cr_r, sp_r, cp_r, sy_r, cy_r, cysp_r, sysp_r;
  logic signed [33:0] p_r [9];
  logic signed [33:0] m_r [9];
  logic               v1_r, v2_r, v3_r;
  in_word_t           w1_r, w2_r, w3_r;

  function automatic logic signed [33:0] qm(input logic signed [33:0] a,
                                            input logic signed [33:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b);
    return 34'(rnd30(p));
  endfunction

  function automatic logic signed [15:0] ent(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] q;
    logic signed [34:0] r;
    m = v[33] ? 34'(-v) : v;
    q = (m + ((34'd1 << (30 - FRAC_BITS)) >> 1)) >> (30 - FRAC_BITS);
    r = v[33] ? -35'(q) : 35'(q);
    if (r > (35'sd1 <<< FRAC_BITS)) r = 35'sd1 <<< FRAC_BITS;
    else if (r < -(35'sd1 <<< FRAC_BITS)) r = -(35'sd1 <<< FRAC_BITS);
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  // stage 1: pitch-coupled products
  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r <= in_word;
      sr_r <= sin_in[0 +: 34];  cr_r <= cos_in[0 +: 34];
      sp_r <= sin_in[34 +: 34]; cp_r <= cos_in[34 +: 34];
      sy_r <= sin_in[68 +: 34]; cy_r <= cos_in[68 +: 34];
      cysp_r <= qm(cos_in[68 +: 34], sin_in[34 +: 34]);
      sysp_r <= qm(sin_in[68 +: 34], sin_in[34 +: 34]);
    end
  end

  // stage 2: remaining products
  always_ff @(posedge clk) begin
    if (adv) begin
      w2_r <= w1_r;
      p_r[0] <= qm(cy_r, cp_r);
      p_r[1] <= qm(cysp_r, sr_r) - qm(sy_r, cr_r);
      p_r[2] <= qm(cysp_r, cr_r) + qm(sy_r, sr_r);
      p_r[3] <= qm(sy_r, cp_r);
      p_r[4] <= qm(sysp_r, sr_r) + qm(cy_r, cr_r);
      p_r[5] <= qm(sysp_r, cr_r) - qm(cy_r, sr_r);
      p_r[6] <= -sp_r;
      p_r[7] <= qm(cp_r, sr_r);
      p_r[8] <= qm(cp_r, cr_r);
    end
  end

  // stage 3: register ahead of the rounding to entry format
  always_ff @(posedge clk) begin
    if (adv) begin
      w3_r <= w2_r;
      for (int k = 0; k < 9; k++) m_r[k] <= p_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) ent_out[k*16 +: 16] = ent(m_r[k]);
  end

  assign out_valid = v3_r;
  assign out_word  = w3_r;
endmodule

### src/ezr_rows.sv
// serialises the matrix into three row words
module ezr_rows (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ezr_pkg::in_word_t      in_word,
  input  logic signed [9*16-1:0] ent_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ezr_pkg::out_word_t     out_word
);
  import ezr_pkg::*;

  logic               busy_r, busy_nxt;
  logic [1:0]         row_r, row_nxt;
  logic signed [15:0] e_r [9];
  logic signed [31:0] t_r [3];
  logic               take;

  assign in_stall  = busy_r && !(row_r == ROW_LAST && !out_stall);
  assign take      = in_valid && !in_stall;
  assign out_valid = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (busy_r && !out_stall) begin
      if (row_r == ROW_LAST) busy_nxt = 1'b0;
      row_nxt = row_r + 2'd1;
    end
    if (take) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < 9; k++) e_r[k] <= ent_in[k*16 +: 16];
      t_r[0] <= in_word.shift_x;
      t_r[1] <= in_word.shift_y;
      t_r[2] <= in_word.shift_z;
    end
  end

  // row select
  always_comb begin
    out_word.row_index = row_r;
    out_word.last_row  = (row_r == ROW_LAST);
    case (row_r)
      2'd0: begin
        out_word.col0 = e_r[0]; out_word.col1 = e_r[1]; out_word.col2 = e_r[2];
        out_word.shift_out = t_r[0];
      end
      2'd1: begin
        out_word.col0 = e_r[3]; out_word.col1 = e_r[4]; out_word.col2 = e_r[5];
        out_word.shift_out = t_r[1];
      end
      default: begin
        out_word.col0 = e_r[6]; out_word.col1 = e_r[7]; out_word.col2 = e_r[8];
        out_word.shift_out = t_r[2];
      end
    endcase
  end
endmodule

### src/euler_zyx_to_rigid_transform_top.sv
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | angles and translation
// out     | output    | out_valid/out_stall| one matrix row [R|t]
// an item enters in any cycle the pipeline tail is empty or the row stage can take it; results
// leave one row a cycle while out_stall is low, so the single output port sets the sustained rate.
// from input to first row an item passes the prep register, 7 cordic stages, 3 matrix stages and the row stage.
// reset is synchronous, active low, and clears only valid bits and the row counter.
// a row stall freezes the pipeline once its tail holds an item; nothing is lost or repeated.
module euler_zyx_to_rigid_transform_top #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ezr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ezr_pkg::out_word_t out_data
);
  import ezr_pkg::*;

  logic                   c_valid, m_valid, row_stall, adv;
  in_word_t               c_word, m_word;
  logic signed [3*34-1:0] sn, cs;
  logic signed [9*16-1:0] ent;

  // pipeline moves when the tail is empty or taken
  assign adv      = !(m_valid && row_stall);
  assign in_stall = !adv;

  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk, .rst_n, .adv, .in_valid, .in_word(in_data),
    .out_valid(c_valid), .out_word(c_word), .sin_out(sn), .cos_out(cs)
  );

  ezr_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk, .rst_n, .adv, .in_valid(c_valid), .in_word(c_word),
    .sin_in(sn), .cos_in(cs),
    .out_valid(m_valid), .out_word(m_word), .ent_out(ent)
  );

  ezr_rows u_rows (
    .clk, .rst_n, .in_valid(m_valid), .in_stall(row_stall), .in_word(m_word),
    .ent_in(ent), .out_valid, .out_stall, .out_word(out_data)
  );
endmodule

### src/ezr_checker.sv
module ezr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ezr_pkg::out_word_t out_data
);
  import ezr_pkg::*;

  // row numbers stay in range and the last flag matches row two
  a_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.row_index != 2'd3 &&
                   out_data.last_row == (out_data.row_index == ROW_LAST)))
    else $error("bad row");

  // rows follow in order after a taken word
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_row |=>
      out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");

  // held word does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");
endmodule

bind euler_zyx_to_rigid_transform_top ezr_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);
